FILE: hdl/mkcd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_pkg: shared types and constants
// Key state and event codes, register indexes and the controller/datapath
// command and status bundles of the click/hold detector.
// ---------------------------------------------------------------------------
package mkcd_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int PIN_W            = 8;
	localparam int TIME_W           = 32;
	localparam int CFG_W            = 16;
	localparam int CFG_ADDR_W       = 1;
	localparam int CHAN_OUT_W       = 3;
	localparam int EVENT_W          = 3;
	localparam int COUNT_W          = 8;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_HOLD_THR  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CLICK_INT = 1'd1;

	localparam logic [CFG_W-1:0] HOLD_THR_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] CLICK_INT_RST = 16'd300;

	// per-key state codes
	localparam logic [2:0] KS_IDLE     = 3'd0;
	localparam logic [2:0] KS_PRESSED  = 3'd1;
	localparam logic [2:0] KS_HELD     = 3'd2;
	localparam logic [2:0] KS_RELEASED = 3'd3;
	localparam logic [2:0] KS_REL_HOLD = 3'd4;

	// event codes
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_HOLD    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd3;
	localparam logic [EVENT_W-1:0] EV_CLICK   = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic load;   // capture a new scan
		logic step;   // process and report the current channel
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_ch;   // current channel is the final one
		logic out_free;  // output register can take a result this cycle
	} ctrl_sts_t;

endpackage
`default_nettype wire

FILE: hdl/multi_key_click_hold_detector_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// multi_key_click_hold_detector_top: multi-key click/hold detector
// Per-key press, hold, release and multi-click detection on timestamped scans.
// ---------------------------------------------------------------------------
// Each input transaction is one scan: pin_bits (bit c high = key c down) and
// a millisecond timestamp now_ms that may wrap. For every scan the block
// returns NUM_CHANNELS result transactions in channel order, each carrying
// the channel number (low 3 bits), the latched last event (none, press,
// hold, release, click) and the consecutive click count; last marks the
// final result of the scan. Channels 8 and above see their pin as released.
// One channel is advanced and reported per clock while the output side does
// not stall; the next scan is taken in the same cycle the final channel of
// the current one is reported. A result held in the output register by
// out_stall freezes the channel stepping, and with it the scan input during
// a scan, until that result is taken. The shared per-channel update (two
// 32-bit wrap-around subtract/compares) is the unit that sets this rate.
// hold_threshold (index 0) and click_interval (index 1) are to be written
// through cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this. They reset to 1000 ms and 300 ms.
// ---------------------------------------------------------------------------
module multi_key_click_hold_detector_top #(
	parameter int NUM_CHANNELS = mkcd_pkg::NUM_CHANNELS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration write port
	input  wire                                cfg_we,
	input  wire  [mkcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [mkcd_pkg::CFG_W-1:0]         cfg_wdata,
	// scan input
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [mkcd_pkg::PIN_W-1:0]         pin_bits,
	input  wire  [mkcd_pkg::TIME_W-1:0]        now_ms,
	// per-channel results
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [mkcd_pkg::CHAN_OUT_W-1:0]    channel,
	output logic [mkcd_pkg::EVENT_W-1:0]       event_res,
	output logic [mkcd_pkg::COUNT_W-1:0]       click_count,
	output logic                               last
);
	import mkcd_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: scan acceptance and channel stepping
	mkcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// per-channel state, config registers and output register
	mkcd_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.pin_bits    (pin_bits),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel     (channel),
		.event_res   (event_res),
		.click_count (click_count),
		.last        (last)
	);

endmodule
`default_nettype wire

FILE: hdl/mkcd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_ctrl: scan sequencer
// Accepts a scan transaction and steps the datapath through the channels.
// ---------------------------------------------------------------------------
module mkcd_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  mkcd_pkg::ctrl_sts_t    sts,
	output mkcd_pkg::ctrl_cmd_t    cmd
);
	import mkcd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic step;

	assign step     = (state_q == ST_RUN) && sts.out_free;
	// next scan may enter in the cycle the final channel is reported
	assign in_stall = !((state_q == ST_IDLE) || (step && sts.last_ch));
	assign accept   = in_valid && !in_stall;

	assign cmd.load = accept;
	assign cmd.step = step;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step && sts.last_ch) state_d = accept ? ST_RUN : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_run_accept_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !in_stall) |-> (sts.last_ch && sts.out_free))
		else $error("scan accepted before last channel reported");
	a_step_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == ST_RUN))
		else $error("datapath stepped while idle");
`endif

endmodule
`default_nettype wire

FILE: hdl/mkcd_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mkcd_dp: per-channel state and result datapath
// Holds the key state of every channel, advances one channel per step and
// registers its result.
// ---------------------------------------------------------------------------
module mkcd_dp #(
	parameter int NUM_CHANNELS = mkcd_pkg::NUM_CHANNELS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  mkcd_pkg::ctrl_cmd_t                cmd,
	output mkcd_pkg::ctrl_sts_t                sts,
	input  wire                                cfg_we,
	input  wire  [mkcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [mkcd_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire  [mkcd_pkg::PIN_W-1:0]         pin_bits,
	input  wire  [mkcd_pkg::TIME_W-1:0]        now_ms,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [mkcd_pkg::CHAN_OUT_W-1:0]    channel,
	output logic [mkcd_pkg::EVENT_W-1:0]       event_res,
	output logic [mkcd_pkg::COUNT_W-1:0]       click_count,
	output logic                               last
);
	import mkcd_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	logic [CFG_W-1:0]   hold_thr_q;
	logic [CFG_W-1:0]   click_int_q;
	logic [PIN_W-1:0]   pins_q;
	logic [TIME_W-1:0]  now_q;
	logic [CH_W-1:0]    ch_q;

	logic [2:0]         key_state_q  [NUM_CHANNELS];
	logic [TIME_W-1:0]  press_time_q [NUM_CHANNELS];
	logic [TIME_W-1:0]  click_time_q [NUM_CHANNELS];
	logic [EVENT_W-1:0] last_event_q [NUM_CHANNELS];
	logic [COUNT_W-1:0] click_cnt_q  [NUM_CHANNELS];

	logic               down;
	logic [2:0]         cur_ks;
	logic [TIME_W-1:0]  press_dt;
	logic [TIME_W-1:0]  click_dt;
	logic [2:0]         nxt_ks;
	logic [EVENT_W-1:0] nxt_ev;
	logic [COUNT_W-1:0] nxt_cnt;
	logic               wr_press;
	logic               wr_click;
	logic               last_ch;
	logic               out_free;

	assign last_ch      = (ch_q == CH_LAST);
	assign out_free     = !out_valid || !out_stall;
	assign sts.last_ch  = last_ch;
	assign sts.out_free = out_free;

	// channels past the pin field never read as pressed
	assign down     = (32'(ch_q) < PIN_W) ? pins_q[3'(ch_q)] : 1'b0;
	assign cur_ks   = key_state_q[ch_q];
	assign press_dt = now_q - press_time_q[ch_q];
	assign click_dt = now_q - click_time_q[ch_q];

	always_comb begin
		nxt_ks   = cur_ks;
		nxt_ev   = last_event_q[ch_q];
		nxt_cnt  = click_cnt_q[ch_q];
		wr_press = 1'b0;
		wr_click = 1'b0;
		case (cur_ks)
			KS_IDLE: begin
				if (down) begin
					wr_press = 1'b1;
					nxt_ks   = KS_PRESSED;
					nxt_ev   = EV_PRESS;
				end
			end
			KS_PRESSED: begin
				if (!down) begin
					nxt_ks = KS_RELEASED;
					nxt_ev = EV_RELEASE;
				end else if (press_dt > {{(TIME_W-CFG_W){1'b0}}, hold_thr_q}) begin
					nxt_ks = KS_HELD;
					nxt_ev = EV_HOLD;
				end
			end
			KS_HELD: begin
				if (!down) begin
					nxt_ks = KS_REL_HOLD;
					nxt_ev = EV_RELEASE;
				end
			end
			KS_RELEASED: begin
				// click is reported whatever the pin reads
				if (click_dt < {{(TIME_W-CFG_W){1'b0}}, click_int_q}) begin
					if (click_cnt_q[ch_q] != COUNT_MAX)
						nxt_cnt = click_cnt_q[ch_q] + COUNT_W'(1);
				end else begin
					nxt_cnt = COUNT_W'(1);
				end
				wr_click = 1'b1;
				nxt_ks   = KS_IDLE;
				nxt_ev   = EV_CLICK;
			end
			default: begin
				// release after hold: back to idle, count cleared, event kept
				nxt_ks  = KS_IDLE;
				nxt_cnt = '0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_thr_q  <= HOLD_THR_RST;
			click_int_q <= CLICK_INT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HOLD_THR:  hold_thr_q  <= cfg_wdata;
				REG_CLICK_INT: click_int_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scan capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pins_q <= pin_bits;
			now_q  <= now_ms;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				key_state_q[i]  <= KS_IDLE;
				press_time_q[i] <= '0;
				click_time_q[i] <= '0;
				last_event_q[i] <= EV_NONE;
				click_cnt_q[i]  <= '0;
			end
		end else if (cmd.step) begin
			ch_q                <= last_ch ? '0 : ch_q + CH_W'(1);
			key_state_q[ch_q]   <= nxt_ks;
			last_event_q[ch_q]  <= nxt_ev;
			click_cnt_q[ch_q]   <= nxt_cnt;
			if (wr_press) press_time_q[ch_q] <= now_q;
			if (wr_click) click_time_q[ch_q] <= now_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.step) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			channel     <= CHAN_OUT_W'(ch_q);
			event_res   <= nxt_ev;
			click_count <= nxt_cnt;
			last        <= last_ch;
		end
	end

`ifndef SYNTH
	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> out_free)
		else $error("result overwritten before transfer");
	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && last_ch) |=> (ch_q == '0))
		else $error("channel counter did not wrap");
	a_click_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cur_ks == KS_RELEASED) |=> (click_count != '0))
		else $error("click reported with zero count");
`endif

endmodule
`default_nettype wire
